### rtl/fcr_pkg.sv
// Package for the fraction to clock ratio block: widths, limits and sequencer states.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package fcr_pkg;

  localparam int MAX_DEN   = 63;
  localparam int FRAC_BITS = 32;
  localparam int DEN_W     = $clog2(MAX_DEN + 1);
  localparam int XM_W      = DEN_W + FRAC_BITS;
  localparam int PROD_W    = XM_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_DECIDE = 5'b10000
  } fcr_state_t;

endpackage

### rtl/fraction_to_clock_ratio.sv
// Top level of the fraction to clock ratio block: sequencer and shared add/compare unit.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

// Picks a numerator and denominator, denominator at most 63, that approximate a
// Q0.32 fraction for a fractional clock divider.
// An item is taken on unit_fraction at a clock edge with start high and busy
// low. busy then stays high until the result is shown: numerator and
// denominator are valid for the single cycle in which done is high, and the
// receiver must take them then. A new item may be started in that cycle.
// The special cases (tiny, low and high fractions) raise done from the check
// state after the accepting edge. Otherwise the block walks the Stern-Brocot
// tree, one mediant per cycle through one pair of 39-bit adders and comparators
// that keep running products of the bound denominators with x plus and minus
// tolerance. A match returns at once; running out of denominator passes the exit
// test, then a multiply state and a decision between the upper bound and 0/1.
// match_tolerance is to be written with cfg_write and cfg_data while the block
// is idle; the user must keep to this, the block does not enforce it.
// Synchronous reset returns the block to idle, clears done and sets
// the tolerance to 4295.
module fraction_to_clock_ratio
  import fcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAC_BITS-1:0] unit_fraction,
  input  logic                 cfg_write,
  input  logic [FRAC_BITS-1:0] cfg_data,
  output logic                 done,
  output logic [DEN_W-1:0]     numerator,
  output logic [DEN_W-1:0]     denominator
);

  fcr_state_t              state;
  logic [FRAC_BITS-1:0]    match_tolerance;
  logic [FRAC_BITS-1:0]    x;
  logic [DEN_W-1:0]        ln, ld, un, ud;
  logic [PROD_W-1:0]       pl, pu, ql, qu;
  logic [XM_W-1:0]         ux;

  logic [XM_W-1:0]         x_times_max;
  logic [PROD_W-1:0]       x_plus_tol, x_minus_tol;
  logic [DEN_W:0]          md_sum;
  logic [DEN_W-1:0]        mn, md;
  logic [PROD_W-1:0]       ps, qs, mscaled;

  assign busy = (state != ST_IDLE);

  assign x_times_max = XM_W'(x) * XM_W'(MAX_DEN);
  assign x_plus_tol  = PROD_W'(x) + PROD_W'(match_tolerance);
  assign x_minus_tol = PROD_W'(x) - PROD_W'(match_tolerance);
  assign md_sum      = {1'b0, ld} + {1'b0, ud};
  assign md          = md_sum[DEN_W-1:0];
  assign mn          = ln + un;
  assign ps          = pl + pu;
  assign qs          = ql + qu;
  assign mscaled     = {1'b0, mn, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= FRAC_BITS'(4295);
    end else if (cfg_write) begin
      match_tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (x <= match_tolerance ||
              x_times_max <= (XM_W'(1) << FRAC_BITS) ||
              x_times_max >= (XM_W'(MAX_DEN - 1) << FRAC_BITS)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (md_sum > (DEN_W + 1)'(MAX_DEN)) begin
            state <= ST_MUL;
          end else if (!(ps < mscaled) && !(mscaled < qs)) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_MUL: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          x <= unit_fraction;
        end
      end
      ST_CHECK: begin
        ln <= '0;
        ld <= DEN_W'(1);
        un <= DEN_W'(1);
        ud <= DEN_W'(1);
        pl <= x_plus_tol;
        pu <= x_plus_tol;
        ql <= x_minus_tol;
        qu <= x_minus_tol;
        priority if (x <= match_tolerance) begin
          numerator   <= '0;
          denominator <= DEN_W'(1);
        end else if (x_times_max <= (XM_W'(1) << FRAC_BITS)) begin
          numerator   <= '0;
          denominator <= DEN_W'(2);
        end else begin
          numerator   <= DEN_W'(2);
          denominator <= DEN_W'(2);
        end
      end
      ST_STEP: begin
        if (md_sum <= (DEN_W + 1)'(MAX_DEN)) begin
          priority if (ps < mscaled) begin
            un <= mn;
            ud <= md;
            pu <= ps;
            qu <= qs;
          end else if (mscaled < qs) begin
            ln <= mn;
            ld <= md;
            pl <= ps;
            ql <= qs;
          end else begin
            numerator   <= mn;
            denominator <= md;
          end
        end
      end
      ST_MUL: begin
        ux <= XM_W'(ud) * XM_W'(x);
      end
      ST_DECIDE: begin
        if ({1'b0, un, {FRAC_BITS{1'b0}}} < {ux, 1'b0}) begin
          numerator   <= un;
          denominator <= ud;
        end else begin
          numerator   <= '0;
          denominator <= DEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/fcr_checker.sv
// Port-level checker for the fraction to clock ratio block, bound to the top level.
// Depends on fcr_pkg and fraction_to_clock_ratio.
`timescale 1ns / 1ps

module fcr_checker
  import fcr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [FRAC_BITS-1:0] unit_fraction,
  input logic                 cfg_write,
  input logic [FRAC_BITS-1:0] cfg_data,
  input logic                 done,
  input logic [DEN_W-1:0]     numerator,
  input logic [DEN_W-1:0]     denominator
);

  a_den_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (denominator != '0 && denominator <= DEN_W'(MAX_DEN)))
    else $error("denominator out of range");

  a_num_le_den: assert property (@(posedge clk) disable iff (rst)
    done |-> (numerator <= denominator))
    else $error("numerator above denominator");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not make the block busy");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && !$past(done)))
    else $error("result shown while busy or twice");

endmodule

bind fraction_to_clock_ratio fcr_checker u_fcr_checker (.*);
